FILE: sv/i2c_register_map_adc_averaging_unit_macros.svh
// Assertion macros shared by the I2C register map and ADC averaging unit.
`ifndef I2C_REGISTER_MAP_ADC_AVERAGING_UNIT_MACROS_SVH
`define I2C_REGISTER_MAP_ADC_AVERAGING_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define I2CADC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define I2CADC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define I2CADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/i2cadc_pkg.sv
// Package with item types, command codes and register map constants.
`timescale 1ns / 1ps
package i2cadc_pkg;

  localparam int unsigned PTR_W = 7;
  localparam int unsigned MAP_CHANNELS = 9;

  typedef enum logic [2:0] {
    CMD_ADDR_MATCH = 3'd0,
    CMD_WRITE_BYTE = 3'd1,
    CMD_READ_BYTE  = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_BUS_RESET  = 3'd4,
    CMD_ADC_SAMPLE = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_BOARD_KIND       = 2'd0,
    CFG_FIRMWARE_VERSION = 2'd1,
    CFG_HARDWARE_VERSION = 2'd2
  } cfg_idx_e;

  localparam logic [PTR_W-1:0] REG_BOARD_KIND       = 7'h00;
  localparam logic [PTR_W-1:0] REG_FIRMWARE_VERSION = 7'h01;
  localparam logic [PTR_W-1:0] REG_HARDWARE_VERSION = 7'h02;
  localparam logic [PTR_W-1:0] REG_COMMAND          = 7'h03;
  localparam logic [PTR_W-1:0] REG_SOC_TEMP         = 7'h04;
  localparam logic [PTR_W-1:0] REG_BOARD_TEMP       = 7'h05;
  localparam logic [PTR_W-1:0] REG_IRQ_FIRST        = 7'h06;
  localparam logic [PTR_W-1:0] REG_IRQ_LAST         = 7'h09;

  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  // Averaged channels visible on the bus, with their high and low byte addresses.
  localparam logic [3:0] MEAN_CHAN [MAP_CHANNELS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd8, 4'd9, 4'd14, 4'd15
  };
  localparam logic [PTR_W-1:0] MEAN_HI_ADDR [MAP_CHANNELS] = '{
    7'h29, 7'h31, 7'h33, 7'h35, 7'h37, 7'h39, 7'h41, 7'h43, 7'h45
  };
  localparam logic [PTR_W-1:0] MEAN_LO_ADDR [MAP_CHANNELS] = '{
    7'h30, 7'h32, 7'h34, 7'h36, 7'h38, 7'h40, 7'h42, 7'h44, 7'h46
  };

  typedef struct packed {
    logic [2:0]  command;
    logic        dir_is_write;
    logic [7:0]  data_byte;
    logic [3:0]  channel;
    logic [11:0] sample;
    logic [7:0]  soc_temp;
    logic [7:0]  board_temp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  active_command;
    logic [11:0] channel_average;
  } out_item_t;

endpackage

FILE: sv/i2cadc_stream_if.sv
// Valid/ready channel that carries one item per handshake.
`timescale 1ns / 1ps
interface i2cadc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/i2cadc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module i2cadc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/i2c_register_map_adc_averaging_unit.sv
// Top level of the I2C register map with its bank of ADC moving-average filters.
//
//   channel   direction  handshake        carries
//   item_i    in         valid / ready    bus event or ADC sample
//   result_o  out        valid / ready    read byte, active command, channel average
//   apb       in         psel / penable   identification bytes
//
// One item is accepted per cycle while the output is not stalled; its result passes
// through the processing stage register into the output register. The sample store
// RAM is read when a sample is accepted and written in the processing stage, which
// also updates the pointer, commands and running sums. Reset clears the pointer,
// commands, running sums, slot counters and fill flags; no clearing pass runs.
// A stalled output holds the processing stage, which in turn holds off new items.
`timescale 1ns / 1ps
`include "i2c_register_map_adc_averaging_unit_macros.svh"
module i2c_register_map_adc_averaging_unit
  import i2cadc_pkg::*;
#(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned DEPTH_SHIFT = 2,
  parameter int unsigned REG_COUNT   = 71,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  i2cadc_stream_if.sink          item_i,
  i2cadc_stream_if.source        result_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned RAM_D   = CHANNELS << DEPTH_SHIFT;
  localparam int unsigned AW      = $clog2(RAM_D);
  localparam int unsigned SUM_W   = SAMPLE_BITS + DEPTH_SHIFT;
  localparam logic [8:0]  RC1     = 9'(REG_COUNT);
  localparam logic [8:0]  RC2     = 9'(2 * REG_COUNT);

  typedef struct packed {
    logic [2:0]             command;
    logic                   dir_is_write;
    logic [7:0]             data_byte;
    logic                   ch_ok;
    logic [CH_W-1:0]        ch_idx;
    logic [DEPTH_SHIFT-1:0] slot;
    logic                   filled;
    logic [SAMPLE_BITS-1:0] smp;
    logic [7:0]             soc_temp;
    logic [7:0]             board_temp;
  } stage_t;

  // Configuration registers.
  logic [7:0] cfg_q [3];
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= '0;
      cfg_q[1] <= '0;
      cfg_q[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_e'(paddr[3:2]))
        CFG_BOARD_KIND:       cfg_q[0] <= pwdata[7:0];
        CFG_FIRMWARE_VERSION: cfg_q[1] <= pwdata[7:0];
        CFG_HARDWARE_VERSION: cfg_q[2] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_e'(paddr[3:2]))
      CFG_BOARD_KIND:       prdata = 32'(cfg_q[0]);
      CFG_FIRMWARE_VERSION: prdata = 32'(cfg_q[1]);
      CFG_HARDWARE_VERSION: prdata = 32'(cfg_q[2]);
      default:              prdata = '0;
    endcase
  end

  // Handshake control.
  logic      s1_valid_q;
  logic      out_valid_q;
  logic      s1_adv;
  logic      in_fire;
  stage_t    s1_q;
  stage_t    s1_d;
  out_item_t out_q;
  out_item_t out_d;
  cmd_e      s1_cmd;

  assign s1_adv        = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready  = !s1_valid_q || s1_adv;
  assign in_fire       = item_i.valid && item_i.ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;
  assign s1_cmd        = cmd_e'(s1_q.command);

  // Accept side: slot counters advance here so the next sample sees them at once.
  logic [DEPTH_SHIFT-1:0] slot_q [CHANNELS];
  logic                   filled_q [CHANNELS];
  logic [CH_W-1:0]        in_ch_idx;
  logic                   in_ch_ok;
  logic                   in_is_sample;
  logic [15:0]            in_smp_wide;
  logic [DEPTH_SHIFT-1:0] in_slot;
  logic                   in_filled;

  assign in_ch_idx    = item_i.payload.channel[CH_W-1:0];
  assign in_ch_ok     = {1'b0, item_i.payload.channel} < 5'(CHANNELS);
  assign in_is_sample = cmd_e'(item_i.payload.command) == CMD_ADC_SAMPLE;
  assign in_smp_wide  = 16'(item_i.payload.sample);
  assign in_slot      = in_ch_ok ? slot_q[in_ch_idx] : '0;
  assign in_filled    = in_ch_ok ? filled_q[in_ch_idx] : 1'b0;

  always_comb begin
    s1_d.command      = item_i.payload.command;
    s1_d.dir_is_write = item_i.payload.dir_is_write;
    s1_d.data_byte    = item_i.payload.data_byte;
    s1_d.ch_ok        = in_ch_ok;
    s1_d.ch_idx       = in_ch_idx;
    s1_d.slot         = in_slot;
    s1_d.filled       = in_filled;
    s1_d.smp          = in_smp_wide[SAMPLE_BITS-1:0];
    s1_d.soc_temp     = item_i.payload.soc_temp;
    s1_d.board_temp   = item_i.payload.board_temp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_q[i]   <= '0;
        filled_q[i] <= 1'b0;
      end
    end else if (in_fire && in_is_sample && in_ch_ok) begin
      slot_q[in_ch_idx] <= in_slot + 1'b1;
      // Once the slot wraps, every entry of the channel holds a written sample.
      if (in_slot == {DEPTH_SHIFT{1'b1}}) begin
        filled_q[in_ch_idx] <= 1'b1;
      end
    end
  end

  // Sample store.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign ram_re    = in_fire && in_is_sample && in_ch_ok;
  assign ram_raddr = AW'({in_ch_idx, in_slot});
  assign ram_we    = s1_adv && s1_cmd == CMD_ADC_SAMPLE && s1_q.ch_ok;
  assign ram_waddr = AW'({s1_q.ch_idx, s1_q.slot});

  i2cadc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_D)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s1_q.smp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Processing stage state.
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic                   load_pend_q, load_pend_d;
  logic [7:0]             pend_cmd_q, pend_cmd_d;
  logic [7:0]             latched_q, latched_d;
  logic [SUM_W-1:0]       sum_q [CHANNELS];
  logic [SUM_W-1:0]       sum_new;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SAMPLE_BITS-1:0] mean_new;
  logic [15:0]            mean_new_wide;
  logic [SAMPLE_BITS-1:0] mean_all [16];
  logic [8:0]             mod_r0, mod_r1, mod_r2;
  logic [PTR_W:0]         ptr_inc;
  logic [PTR_W-1:0]       ptr_step;
  logic [7:0]             rd_byte;

  for (genvar k = 0; k < 16; k++) begin : g_mean
    if (k < CHANNELS) begin : g_on
      assign mean_all[k] = SAMPLE_BITS'(sum_q[k] >> DEPTH_SHIFT);
    end else begin : g_off
      assign mean_all[k] = '0;
    end
  end

  // Pointer load: the byte is below four times the register count.
  assign mod_r0 = {1'b0, s1_q.data_byte};
  assign mod_r1 = (mod_r0 >= RC2) ? mod_r0 - RC2 : mod_r0;
  assign mod_r2 = (mod_r1 >= RC1) ? mod_r1 - RC1 : mod_r1;

  assign ptr_inc  = {1'b0, ptr_q} + 1'b1;
  assign ptr_step = (ptr_inc == (PTR_W + 1)'(REG_COUNT)) ? '0 : ptr_inc[PTR_W-1:0];

  assign old_smp       = s1_q.filled ? ram_rdata : '0;
  assign sum_new       = sum_q[s1_q.ch_idx] - SUM_W'(old_smp) + SUM_W'(s1_q.smp);
  assign mean_new      = SAMPLE_BITS'(sum_new >> DEPTH_SHIFT);
  assign mean_new_wide = 16'(mean_new);

  always_comb begin
    logic [15:0] m;
    m = '0;
    if (ptr_q == REG_BOARD_KIND) begin
      rd_byte = cfg_q[0];
    end else if (ptr_q == REG_FIRMWARE_VERSION) begin
      rd_byte = cfg_q[1];
    end else if (ptr_q == REG_HARDWARE_VERSION) begin
      rd_byte = cfg_q[2];
    end else if (ptr_q == REG_SOC_TEMP) begin
      rd_byte = s1_q.soc_temp;
    end else if (ptr_q == REG_BOARD_TEMP) begin
      rd_byte = s1_q.board_temp;
    end else if (ptr_q == REG_COMMAND
                 || (ptr_q >= REG_IRQ_FIRST && ptr_q <= REG_IRQ_LAST)) begin
      rd_byte = 8'h00;
    end else begin
      rd_byte = UNMAPPED_BYTE;
    end
    for (int i = 0; i < MAP_CHANNELS; i++) begin
      m = 16'(mean_all[MEAN_CHAN[i]]);
      if (ptr_q == MEAN_HI_ADDR[i]) begin
        rd_byte = m[15:8];
      end
      if (ptr_q == MEAN_LO_ADDR[i]) begin
        rd_byte = m[7:0];
      end
    end
  end

  always_comb begin
    ptr_d       = ptr_q;
    load_pend_d = load_pend_q;
    pend_cmd_d  = pend_cmd_q;
    latched_d   = latched_q;
    out_d.read_data       = 8'h00;
    out_d.channel_average = '0;
    case (s1_cmd)
      CMD_ADDR_MATCH: begin
        if (s1_q.dir_is_write) begin
          load_pend_d = 1'b1;
        end
      end
      CMD_WRITE_BYTE: begin
        if (load_pend_q) begin
          ptr_d       = mod_r2[PTR_W-1:0];
          load_pend_d = 1'b0;
        end else begin
          if (ptr_q == REG_COMMAND) begin
            pend_cmd_d = s1_q.data_byte;
          end
          ptr_d = ptr_step;
        end
      end
      CMD_READ_BYTE: begin
        out_d.read_data = rd_byte;
        ptr_d           = ptr_step;
      end
      CMD_STOP: begin
        latched_d = pend_cmd_q;
      end
      CMD_BUS_RESET: begin
        ptr_d       = '0;
        load_pend_d = 1'b0;
        pend_cmd_d  = '0;
        latched_d   = '0;
      end
      CMD_ADC_SAMPLE: begin
        if (s1_q.ch_ok) begin
          out_d.channel_average = mean_new_wide[11:0];
        end
      end
      default: ;
    endcase
    out_d.active_command = latched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      load_pend_q <= 1'b0;
      pend_cmd_q  <= '0;
      latched_q   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        ptr_q       <= ptr_d;
        load_pend_q <= load_pend_d;
        pend_cmd_q  <= pend_cmd_d;
        latched_q   <= latched_d;
        if (s1_cmd == CMD_ADC_SAMPLE && s1_q.ch_ok) begin
          sum_q[s1_q.ch_idx] <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  `I2CADC_ASSERT(a_ptr_in_range, 8'(ptr_q) < 8'(REG_COUNT), "register pointer out of range")
  `I2CADC_ASSERT_NEXT(a_bus_reset_clears, s1_adv && s1_cmd == CMD_BUS_RESET, ptr_q == '0 && !load_pend_q && latched_q == '0, "bus reset left context behind")
  `I2CADC_ASSERT_NEXT(a_read_data_zero, s1_adv && s1_cmd != CMD_READ_BYTE, out_q.read_data == 8'h00, "read data set on a non-read item")
  `I2CADC_ASSERT_IMP(a_stall_blocks_input, s1_valid_q && out_valid_q && !result_o.ready, !item_i.ready, "item taken while the pipeline is stalled")

endmodule

FILE: bench/i2c_register_map_adc_averaging_unit_tb.sv
// Self-checking testbench for the I2C register map and ADC averaging unit.
`timescale 1ns / 1ps
module i2c_register_map_adc_averaging_unit_tb;
  import i2cadc_pkg::*;

  localparam int unsigned NUM_CHANNELS  = 16;
  localparam int unsigned FILTER_TAPS   = 4;
  localparam int unsigned MAP_SIZE      = 71;
  localparam int unsigned RANDOM_ITEMS  = 2000;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned MAX_PRINTS    = 20;

  // Command codes outside the defined set; the block must ignore them.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Averaged channels on the bus and their high and low byte addresses.
  localparam logic [3:0] AVG_CHANNEL [9] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd8, 4'd9, 4'd14, 4'd15
  };
  localparam logic [6:0] AVG_HI_ADDR [9] = '{
    7'h29, 7'h31, 7'h33, 7'h35, 7'h37, 7'h39, 7'h41, 7'h43, 7'h45
  };
  localparam logic [6:0] AVG_LO_ADDR [9] = '{
    7'h30, 7'h32, 7'h34, 7'h36, 7'h38, 7'h40, 7'h42, 7'h44, 7'h46
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cadc_stream_if #(.item_t(in_item_t))  event_if ();
  i2cadc_stream_if #(.item_t(out_item_t)) result_if ();

  i2c_register_map_adc_averaging_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (event_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state of the filters and the register map.
  logic [11:0] tap_value [NUM_CHANNELS*FILTER_TAPS];
  logic [13:0] tap_sum [NUM_CHANNELS];
  logic [1:0]  tap_next [NUM_CHANNELS];
  logic [11:0] avg_value [NUM_CHANNELS];
  logic [6:0]  map_pointer;
  logic        pointer_load_armed;
  logic [7:0]  staged_cmd;
  logic [7:0]  active_cmd;
  logic [7:0]  id_byte [3];

  out_item_t   expected_results [$];
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cfg_settings;
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned idle_cycles;
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned stall_phase;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
  endtask

  function automatic logic [7:0] map_read_byte(logic [6:0] addr, in_item_t it);
    logic [7:0] value;
    value = UNMAPPED_BYTE;
    if (addr >= REG_IRQ_FIRST && addr <= REG_IRQ_LAST) begin
      value = 8'h00;
    end else begin
      case (addr)
        REG_BOARD_KIND:       value = id_byte[CFG_BOARD_KIND];
        REG_FIRMWARE_VERSION: value = id_byte[CFG_FIRMWARE_VERSION];
        REG_HARDWARE_VERSION: value = id_byte[CFG_HARDWARE_VERSION];
        REG_COMMAND:          value = 8'h00;
        REG_SOC_TEMP:         value = it.soc_temp;
        REG_BOARD_TEMP:       value = it.board_temp;
        default: begin
          for (int k = 0; k < 9; k++) begin
            if (addr == AVG_HI_ADDR[k]) value = {4'h0, avg_value[AVG_CHANNEL[k]][11:8]};
            if (addr == AVG_LO_ADDR[k]) value = avg_value[AVG_CHANNEL[k]][7:0];
          end
        end
      endcase
    end
    return value;
  endfunction

  function automatic out_item_t predict_event(in_item_t it);
    out_item_t  res;
    logic [5:0] pos;
    res = '0;
    case (it.command)
      CMD_ADDR_MATCH: if (it.dir_is_write) pointer_load_armed = 1'b1;
      CMD_WRITE_BYTE: begin
        if (pointer_load_armed) begin
          map_pointer = 7'(it.data_byte % MAP_SIZE);
          pointer_load_armed = 1'b0;
        end else begin
          if (map_pointer == REG_COMMAND) staged_cmd = it.data_byte;
          map_pointer = (map_pointer == 7'(MAP_SIZE - 1)) ? 7'd0 : map_pointer + 7'd1;
        end
      end
      CMD_READ_BYTE: begin
        // A read leaves an armed pointer load armed.
        res.read_data = map_read_byte(map_pointer, it);
        map_pointer = (map_pointer == 7'(MAP_SIZE - 1)) ? 7'd0 : map_pointer + 7'd1;
      end
      CMD_STOP: active_cmd = staged_cmd;
      CMD_BUS_RESET: begin
        map_pointer = '0;
        pointer_load_armed = 1'b0;
        staged_cmd = '0;
        active_cmd = '0;
      end
      CMD_ADC_SAMPLE: begin
        pos = {it.channel, tap_next[it.channel]};
        tap_sum[it.channel] = tap_sum[it.channel] - 14'(tap_value[pos]) + 14'(it.sample);
        tap_value[pos] = it.sample;
        tap_next[it.channel] = tap_next[it.channel] + 2'd1;
        avg_value[it.channel] = tap_sum[it.channel][13:2];
        res.channel_average = avg_value[it.channel];
      end
      default: ;
    endcase
    res.active_command = active_cmd;
    return res;
  endfunction

  function automatic in_item_t random_item(logic [2:0] cmd);
    in_item_t it;
    it.command      = cmd;
    it.dir_is_write = 1'($urandom_range(0, 1));
    it.data_byte    = 8'($urandom_range(0, 255));
    it.channel      = 4'($urandom_range(0, 15));
    it.sample       = 12'($urandom_range(0, 4095));
    it.soc_temp     = 8'($urandom_range(0, 255));
    it.board_temp   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Pointer bytes favor the command register (with its aliases above the map size)
  // and the average region, so that command writes and average reads are common.
  function automatic logic [7:0] pick_pointer_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'(REG_COMMAND + MAP_SIZE * $urandom_range(0, 2));
    if (r < 7) return 8'($urandom_range(AVG_HI_ADDR[0], AVG_LO_ADDR[8]));
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      event_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    event_if.valid   <= 1'b1;
    event_if.payload <= it;
    @(posedge clk_i);
    while (!event_if.ready) @(posedge clk_i);
    expected_results.push_back(predict_event(it));
    items_accepted++;
    @(negedge clk_i);
  endtask

  task automatic bus_addr(logic write_dir);
    in_item_t it;
    it = random_item(CMD_ADDR_MATCH);
    it.dir_is_write = write_dir;
    send_item(it);
  endtask

  task automatic bus_write(logic [7:0] value);
    in_item_t it;
    it = random_item(CMD_WRITE_BYTE);
    it.data_byte = value;
    send_item(it);
  endtask

  task automatic bus_read(logic [7:0] soc, logic [7:0] brd);
    in_item_t it;
    it = random_item(CMD_READ_BYTE);
    it.soc_temp   = soc;
    it.board_temp = brd;
    send_item(it);
  endtask

  task automatic bus_cmd(logic [2:0] cmd);
    send_item(random_item(cmd));
  endtask

  task automatic adc_sample(logic [3:0] ch, logic [11:0] value);
    in_item_t it;
    it = random_item(CMD_ADC_SAMPLE);
    it.channel = ch;
    it.sample  = value;
    send_item(it);
  endtask

  task automatic wait_drained();
    event_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Each transfer ends by driving psel and penable low before returning, so the next one starts from an idle bus.
  task automatic apb_write(cfg_idx_e idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    id_byte[idx] = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_check(cfg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== id_byte[idx])
      report_mismatch("register readback", prdata[7:0], id_byte[idx]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Filter extremes, pointer load corner cases, command promotion, bus reset and
  // spare command codes, all with the identification bytes at their reset value.
  task automatic test_filter_and_map_corners();
    repeat (4) adc_sample(4'd0, 12'hFFF);
    adc_sample(4'd15, 12'hFFF);
    adc_sample(4'd15, 12'h000);
    bus_addr(1'b1);
    bus_read(8'h00, 8'hFF);
    bus_write(8'h29);
    bus_read(8'hFF, 8'h00);
    bus_addr(1'b0);
    bus_read(8'h00, 8'h00);
    bus_addr(1'b1);
    bus_write(8'hFF);
    bus_addr(1'b1);
    bus_write({1'b0, REG_COMMAND});
    bus_write(8'hFF);
    bus_cmd(CMD_STOP);
    bus_read(8'hFF, 8'h00);
    bus_read(8'h00, 8'hFF);
    bus_cmd(CMD_BUS_RESET);
    bus_cmd(CMD_SPARE_6);
    bus_cmd(CMD_SPARE_7);
    bus_addr(1'b1);
    bus_write(8'h46);
    bus_read(8'hA5, 8'h5A);
    bus_read(8'h5A, 8'hA5);
  endtask

  task automatic test_identification_bytes();
    logic [7:0] settings [3][3];
    settings = '{'{8'hFF, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 8'h00}, '{8'hA5, 8'h5A, 8'h3C}};
    wait_drained();
    for (int r = 0; r < 3; r++) apb_check(cfg_idx_e'(r));
    for (int s = 0; s < 3; s++) begin
      wait_drained();
      for (int r = 0; r < 3; r++) apb_write(cfg_idx_e'(r), settings[s][r]);
      for (int r = 0; r < 3; r++) apb_check(cfg_idx_e'(r));
      cfg_settings++;
      bus_addr(1'b1);
      bus_write({1'b0, REG_BOARD_KIND});
      bus_cmd(CMD_STOP);
      bus_addr(1'b0);
      repeat (3) bus_read(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      bus_cmd(CMD_STOP);
    end
  endtask

  // Mostly well-formed write and read transactions and sample bursts, with some
  // stray events, bus resets and spare codes mixed in.
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned kind;
    int unsigned count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      for (int r = 0; r < 3; r++) apb_write(cfg_idx_e'(r), 8'($urandom_range(0, 255)));
      cfg_settings++;
      target = items_accepted + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_accepted < target) begin
        gaps_on = ($urandom_range(0, 4) != 0);
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          bus_addr(1'b1);
          bus_write(pick_pointer_byte());
          count = $urandom_range(0, 4);
          repeat (count) bus_write(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) != 0) bus_cmd(CMD_STOP);
        end else if (kind < 60) begin
          bus_addr(1'b1);
          bus_write(pick_pointer_byte());
          if ($urandom_range(0, 1) != 0) bus_cmd(CMD_STOP);
          bus_addr(1'b0);
          count = $urandom_range(1, 6);
          repeat (count) bus_read(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          bus_cmd(CMD_STOP);
        end else if (kind < 85) begin
          count = $urandom_range(1, 8);
          repeat (count) begin
            if ($urandom_range(0, 4) == 0)
              adc_sample(4'($urandom_range(0, 15)), ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000);
            else
              adc_sample(4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
          end
        end else begin
          count = $urandom_range(1, 4);
          repeat (count) bus_cmd(3'($urandom_range(0, 7)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none expected", result_if.payload, 0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result_if.payload.read_data !== want.read_data)
          report_mismatch("read_data", result_if.payload.read_data, want.read_data);
        if (result_if.payload.active_command !== want.active_command)
          report_mismatch("active_command", result_if.payload.active_command,
                          want.active_command);
        if (result_if.payload.channel_average !== want.channel_average)
          report_mismatch("channel_average", result_if.payload.channel_average,
                          want.channel_average);
      end
    end
  end

  // Receiver backpressure: stretches of full rate, random stalls and a fixed rhythm.
  always @(negedge clk_i) begin
    logic next_ready;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       next_ready = 1'b1;
      1:       next_ready = ($urandom_range(0, 3) != 0);
      default: next_ready = (stall_phase % 9) < 5;
    endcase
    result_if.ready <= next_ready;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (event_if.valid && event_if.ready) ||
        (result_if.valid && result_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("i2c_register_map_adc_averaging_unit test failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    event_if.valid   = 1'b0;
    event_if.payload = '0;
    result_if.ready  = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    for (int i = 0; i < NUM_CHANNELS * FILTER_TAPS; i++) tap_value[i] = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      tap_sum[c]   = '0;
      tap_next[c]  = '0;
      avg_value[c] = '0;
    end
    for (int r = 0; r < 3; r++) id_byte[r] = '0;
    map_pointer        = '0;
    pointer_load_armed = 1'b0;
    staged_cmd         = '0;
    active_cmd         = '0;
    items_accepted     = 0;
    results_checked    = 0;
    mismatch_count     = 0;
    cfg_settings       = 0;
    burst_left         = 0;
    gaps_on            = 1'b1;
    idle_cycles        = 0;
    stall_mode         = 0;
    mode_left          = 0;
    stall_phase        = 0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_filter_and_map_corners();
    test_identification_bytes();
    test_random_traffic();
    wait_drained();

    $display("Covered %0d items: I2C transfers, stops, bus resets, spare codes, ADC samples;",
             items_accepted);
    $display("%0d results checked under %0d identification settings, %0d mismatches.",
             results_checked, cfg_settings, mismatch_count);
    if (mismatch_count == 0)
      $display("i2c_register_map_adc_averaging_unit test passed");
    else
      $display("i2c_register_map_adc_averaging_unit test failed");
    $finish;
  end

endmodule
